// ===== rtl/core/smjec_pkg.sv =====
// ============================================================================
// smjec_pkg: shared types and constants for the shooter/jam escape controller
// Mode and jam state encodings, register indexes, reset values, field widths.
// ============================================================================
`default_nettype none

package smjec_pkg;

    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        MODE_RELAX  = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_AUTO   = 2'd2
    } gimbal_mode_t;

    typedef enum logic [1:0] {
        JAM_NORMAL    = 2'd0,
        JAM_BLOCKING  = 2'd1,
        JAM_REVERSING = 2'd2
    } jam_state_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REMOTE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JAM_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JAM_CONFIRM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DUR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_CONFIRM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_SPEED     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SPEED  = 3'd7;

    // register reset values
    localparam logic [15:0] RST_REMOTE_TIMEOUT = 16'd200;
    localparam logic [14:0] RST_JAM_THRESHOLD  = 15'd8500;
    localparam logic [15:0] RST_VALID_LIMIT    = 16'd30000;
    localparam logic [15:0] RST_JAM_CONFIRM    = 16'd150;
    localparam logic [15:0] RST_REVERSE_DUR    = 16'd200;
    localparam logic [3:0]  RST_AUTO_CONFIRM   = 4'd2;
    localparam logic [14:0] RST_FEED_SPEED     = 15'd10000;
    localparam logic [14:0] RST_REVERSE_SPEED  = 15'd2500;

    // one result item, packed lowest field in the lowest bits
    typedef struct packed {
        jam_state_t         jam_state_out;
        logic               angle_resync;
        logic signed [15:0] feeder_speed;
        logic               friction_on;
        logic               shooter_armed;
        gimbal_mode_t       gimbal_mode_out;
        logic               link_up;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/shooter_mode_jam_escape_ctrl_core.sv =====
// ============================================================================
// shooter_mode_jam_escape_ctrl_core: shooter, gimbal mode and feeder jam escape
// One control tick per item in, one command item out.
// ============================================================================
`default_nettype none

// Each accepted tick is processed in the cycle it is accepted: the remote
// timeout check, button edge toggles, auto-fire confirmation counter and the
// feeder jam machine are evaluated in one pass and the command item lands in
// the output register, or in the one-entry skid stage behind it while the
// previous command still waits. One item per clock is sustained while the
// skid stage is empty; s_tready is low while it is full. Configuration
// writes take effect from the next accepted tick.
module shooter_mode_jam_escape_ctrl_core (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // configuration write port
    input  wire                                   cfg_wr_en,
    input  wire [smjec_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [smjec_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // tick input
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // now_ms[31:0], remote_seen_ms[63:32], arm_key[64], relax_request[65],
    // mode_request[66], fire_request[67], reverse_request[68],
    // target_found[69], target_shoot[70], feeder_current[86:71], zero[87]
    input  wire [smjec_pkg::IN_DATA_W-1:0]        s_tdata,
    // command output
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // link_up[0], gimbal_mode_out[2:1], shooter_armed[3],
    // friction_on[4], feeder_speed[20:5], angle_resync[21], jam_state_out[23:22]
    output logic [smjec_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import smjec_pkg::*;

    // configuration registers
    logic [15:0] remote_timeout_reg;
    logic [14:0] jam_threshold_reg;
    logic [15:0] valid_limit_reg;
    logic [15:0] jam_confirm_reg;
    logic [15:0] reverse_dur_reg;
    logic [3:0]  auto_confirm_reg;
    logic [14:0] feed_speed_reg;
    logic [14:0] reverse_speed_reg;

    // controller state
    gimbal_mode_t      mode_reg,      mode_next;
    logic              armed_reg,     armed_next;
    logic              prev_arm_reg,  prev_arm_next;
    logic              prev_relax_reg, prev_relax_next;
    logic              prev_mode_reg, prev_mode_next;
    logic              synced_reg,    synced_next;
    logic [3:0]        confirm_reg,   confirm_next;
    jam_state_t        jam_reg,       jam_next;
    logic [TIME_W-1:0] jam_start_reg, jam_start_next;
    logic [TIME_W-1:0] rev_end_reg,   rev_end_next;

    // output register and skid stage
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    result_t res;

    // input fields
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] seen_ms;
    logic              arm_key, relax_req, mode_req, fire_req, rev_req;
    logic              tgt_found, tgt_shoot;
    logic [15:0]       cur_raw;
    logic [16:0]       cur_mag;
    logic              accept;

    assign now_ms    = s_tdata[31:0];
    assign seen_ms   = s_tdata[63:32];
    assign arm_key   = s_tdata[64];
    assign relax_req = s_tdata[65];
    assign mode_req  = s_tdata[66];
    assign fire_req  = s_tdata[67];
    assign rev_req   = s_tdata[68];
    assign tgt_found = s_tdata[69];
    assign tgt_shoot = s_tdata[70];
    assign cur_raw   = s_tdata[86:71];

    // magnitude of the signed current, -32768 gives 32768
    assign cur_mag = cur_raw[15] ? (17'h10000 - {1'b0, cur_raw}) : {1'b0, cur_raw};

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remote_timeout_reg <= RST_REMOTE_TIMEOUT;
            jam_threshold_reg  <= RST_JAM_THRESHOLD;
            valid_limit_reg    <= RST_VALID_LIMIT;
            jam_confirm_reg    <= RST_JAM_CONFIRM;
            reverse_dur_reg    <= RST_REVERSE_DUR;
            auto_confirm_reg   <= RST_AUTO_CONFIRM;
            feed_speed_reg     <= RST_FEED_SPEED;
            reverse_speed_reg  <= RST_REVERSE_SPEED;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_REMOTE_TIMEOUT: remote_timeout_reg <= cfg_wdata;
                REG_JAM_THRESHOLD:  jam_threshold_reg  <= cfg_wdata[14:0];
                REG_VALID_LIMIT:    valid_limit_reg    <= cfg_wdata;
                REG_JAM_CONFIRM:    jam_confirm_reg    <= cfg_wdata;
                REG_REVERSE_DUR:    reverse_dur_reg    <= cfg_wdata;
                REG_AUTO_CONFIRM:   auto_confirm_reg   <= cfg_wdata[3:0];
                REG_FEED_SPEED:     feed_speed_reg     <= cfg_wdata[14:0];
                REG_REVERSE_SPEED:  reverse_speed_reg  <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // tick evaluation
    always_comb begin
        logic [TIME_W-1:0] silence;
        logic [TIME_W-1:0] jam_age;
        logic              online;
        logic              feed_cmd;
        logic              resync;
        logic              jam_cur;
        logic [15:0]       speed;

        silence   = now_ms - seen_ms;
        jam_age   = now_ms - jam_start_reg;
        online    = !(silence > {{(TIME_W-16){1'b0}}, remote_timeout_reg});
        feed_cmd  = 1'b0;
        resync    = 1'b0;
        speed     = 16'd0;
        jam_cur   = (cur_mag > {2'b00, jam_threshold_reg}) &&
                    (cur_mag < {1'b0, valid_limit_reg});

        mode_next       = mode_reg;
        armed_next      = armed_reg;
        prev_arm_next   = prev_arm_reg;
        prev_relax_next = prev_relax_reg;
        prev_mode_next  = prev_mode_reg;
        synced_next     = synced_reg;
        confirm_next    = confirm_reg;
        jam_next        = jam_reg;
        jam_start_next  = jam_start_reg;
        rev_end_next    = rev_end_reg;

        if (!online) begin
            mode_next    = MODE_RELAX;
            armed_next   = 1'b0;
            synced_next  = 1'b0;
            confirm_next = 4'd0;
        end else begin
            // button edges
            if (arm_key && !prev_arm_reg)
                armed_next = !armed_reg;
            prev_arm_next = arm_key;

            if (relax_req && !prev_relax_reg) begin
                mode_next    = (mode_reg == MODE_RELAX) ? MODE_MANUAL : MODE_RELAX;
                synced_next  = 1'b0;
                confirm_next = 4'd0;
            end
            if (mode_req && !prev_mode_reg && mode_next != MODE_RELAX) begin
                mode_next    = (mode_next == MODE_MANUAL) ? MODE_AUTO : MODE_MANUAL;
                confirm_next = 4'd0;
            end
            prev_relax_next = relax_req;
            prev_mode_next  = mode_req;

            // angle resync and auto-fire confirmation
            if (mode_next != MODE_RELAX) begin
                if (!synced_next) begin
                    resync      = 1'b1;
                    synced_next = 1'b1;
                end
                if (mode_next == MODE_AUTO) begin
                    if (tgt_found && tgt_shoot) begin
                        if (confirm_next < auto_confirm_reg)
                            confirm_next = confirm_next + 4'd1;
                    end else begin
                        confirm_next = 4'd0;
                    end
                end
            end else begin
                confirm_next = 4'd0;
            end

            if (mode_next == MODE_MANUAL)
                feed_cmd = fire_req && armed_next;
            else if (mode_next == MODE_AUTO)
                feed_cmd = fire_req && armed_next && (confirm_next >= auto_confirm_reg);

            // feeder and jam machine
            if (rev_req) begin
                speed        = {1'b0, reverse_speed_reg};
                jam_next     = JAM_NORMAL;
                confirm_next = 4'd0;
            end else if (feed_cmd) begin
                if (jam_reg == JAM_REVERSING) begin
                    speed = {1'b0, reverse_speed_reg};
                    if (now_ms > rev_end_reg)
                        jam_next = JAM_NORMAL;
                end else begin
                    speed = 16'd0 - {1'b0, feed_speed_reg};
                    if (jam_cur) begin
                        if (jam_reg == JAM_NORMAL) begin
                            jam_next       = JAM_BLOCKING;
                            jam_start_next = now_ms;
                        end else if (jam_age > {{(TIME_W-16){1'b0}}, jam_confirm_reg}) begin
                            jam_next     = JAM_REVERSING;
                            rev_end_next = now_ms + {{(TIME_W-16){1'b0}}, reverse_dur_reg};
                        end
                    end else begin
                        jam_next = JAM_NORMAL;
                    end
                end
            end else begin
                jam_next = JAM_NORMAL;
            end
        end

        res.link_up         = online;
        res.gimbal_mode_out = mode_next;
        res.shooter_armed   = armed_next;
        res.friction_on     = online && armed_next;
        res.feeder_speed    = speed;
        res.angle_resync    = resync;
        res.jam_state_out   = jam_next;
    end

    // state update on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_RELAX;
            armed_reg      <= 1'b0;
            prev_arm_reg   <= 1'b0;
            prev_relax_reg <= 1'b0;
            prev_mode_reg  <= 1'b0;
            synced_reg     <= 1'b0;
            confirm_reg    <= 4'd0;
            jam_reg        <= JAM_NORMAL;
            jam_start_reg  <= '0;
            rev_end_reg    <= '0;
        end else if (accept) begin
            mode_reg       <= mode_next;
            armed_reg      <= armed_next;
            prev_arm_reg   <= prev_arm_next;
            prev_relax_reg <= prev_relax_next;
            prev_mode_reg  <= prev_mode_next;
            synced_reg     <= synced_next;
            confirm_reg    <= confirm_next;
            jam_reg        <= jam_next;
            jam_start_reg  <= jam_start_next;
            rev_end_reg    <= rev_end_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept;
                end
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (accept)
                out_data_reg <= res;
        end
        if (accept && out_valid_reg && !m_tready)
            skid_data_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid item held with empty output register");

    a_offline_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_data_reg.link_up) |->
            (!out_data_reg.friction_on && out_data_reg.feeder_speed == 16'sd0 &&
             !out_data_reg.angle_resync && out_data_reg.gimbal_mode_out == MODE_RELAX))
        else $error("offline item drives shooter, feeder or gimbal");

    a_resync_not_relax: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.angle_resync) |->
            out_data_reg.gimbal_mode_out != MODE_RELAX)
        else $error("angle resync in relax mode");

    a_confirm_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && confirm_reg <= auto_confirm_reg) |=>
            (confirm_reg <= auto_confirm_reg || $past(cfg_wr_en)))
        else $error("confirm counter passed its limit");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready) |-> (out_valid_reg && !$past(m_tready)))
        else $error("input stalled without a waiting output item");

endmodule

`default_nettype wire

// ===== dv/smjec_scoreboard_pkg.sv =====
// ============================================================================
// smjec_scoreboard_pkg: command predictor and scoreboard for the controller
// Holds a cycle-free model of the mode, arm and feeder jam logic, queues the
// expected command item for every accepted tick and checks each command item
// coming out of the block field by field.
// ============================================================================

package smjec_scoreboard_pkg;

    import smjec_pkg::*;

    // one tick item, laid out exactly as s_tdata (lowest field in lowest bits)
    typedef struct packed {
        logic        pad;
        logic [15:0] feeder_current;
        logic        target_shoot;
        logic        target_found;
        logic        reverse_request;
        logic        fire_request;
        logic        mode_request;
        logic        relax_request;
        logic        arm_key;
        logic [31:0] remote_seen_ms;
        logic [31:0] now_ms;
    } tick_t;

    class cmd_scoreboard;

        // register copies
        logic [15:0]  timeout_ms;
        logic [14:0]  jam_thr;
        logic [15:0]  valid_lim;
        logic [15:0]  confirm_ms;
        logic [15:0]  rev_dur_ms;
        logic [3:0]   auto_need;
        logic [14:0]  feed_spd;
        logic [14:0]  rev_spd;

        // controller state
        gimbal_mode_t mode;
        bit           armed;
        bit           last_arm;
        bit           last_relax;
        bit           last_mode;
        bit           synced;
        logic [3:0]   streak;
        jam_state_t   jam;
        logic [31:0]  jam_since;
        logic [31:0]  reverse_until;

        result_t      cmd_expected[$];
        int unsigned  errors;
        int unsigned  cmds_checked;

        function new();
            timeout_ms    = RST_REMOTE_TIMEOUT;
            jam_thr       = RST_JAM_THRESHOLD;
            valid_lim     = RST_VALID_LIMIT;
            confirm_ms    = RST_JAM_CONFIRM;
            rev_dur_ms    = RST_REVERSE_DUR;
            auto_need     = RST_AUTO_CONFIRM;
            feed_spd      = RST_FEED_SPEED;
            rev_spd       = RST_REVERSE_SPEED;
            mode          = MODE_RELAX;
            armed         = 1'b0;
            last_arm      = 1'b0;
            last_relax    = 1'b0;
            last_mode     = 1'b0;
            synced        = 1'b0;
            streak        = '0;
            jam           = JAM_NORMAL;
            jam_since     = '0;
            reverse_until = '0;
            errors        = 0;
            cmds_checked  = 0;
        endfunction

        // narrow registers drop the upper write bits
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_REMOTE_TIMEOUT: timeout_ms = v;
                REG_JAM_THRESHOLD:  jam_thr    = v[14:0];
                REG_VALID_LIMIT:    valid_lim  = v;
                REG_JAM_CONFIRM:    confirm_ms = v;
                REG_REVERSE_DUR:    rev_dur_ms = v;
                REG_AUTO_CONFIRM:   auto_need  = v[3:0];
                REG_FEED_SPEED:     feed_spd   = v[14:0];
                REG_REVERSE_SPEED:  rev_spd    = v[14:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return cmd_expected.size();
        endfunction

        // advance the model by one accepted tick and queue its command item
        function void note_tick(tick_t t);
            logic [31:0] silent;
            logic [31:0] jam_age;
            logic [16:0] mag;
            logic [15:0] speed;
            bit          online;
            bit          resync;
            bit          fire_cmd;
            result_t     r;

            silent   = t.now_ms - t.remote_seen_ms;
            mag      = t.feeder_current[15] ? 17'h10000 - {1'b0, t.feeder_current}
                                            : {1'b0, t.feeder_current};
            resync   = 1'b0;
            fire_cmd = 1'b0;
            speed    = '0;

            if (silent > {16'h0, timeout_ms}) begin
                // remote lost: drop modes, hold edges and jam state
                online = 1'b0;
                mode   = MODE_RELAX;
                armed  = 1'b0;
                synced = 1'b0;
                streak = '0;
            end else begin
                online = 1'b1;
                if (t.arm_key && !last_arm)
                    armed = !armed;
                last_arm = t.arm_key;

                if (t.relax_request && !last_relax) begin
                    mode   = (mode == MODE_RELAX) ? MODE_MANUAL : MODE_RELAX;
                    synced = 1'b0;
                    streak = '0;
                end
                if (t.mode_request && !last_mode && mode != MODE_RELAX) begin
                    mode   = (mode == MODE_MANUAL) ? MODE_AUTO : MODE_MANUAL;
                    streak = '0;
                end
                last_relax = t.relax_request;
                last_mode  = t.mode_request;

                // angle resync on first enabled tick, auto-fire streak
                if (mode != MODE_RELAX) begin
                    if (!synced) begin
                        resync = 1'b1;
                        synced = 1'b1;
                    end
                    if (mode == MODE_AUTO) begin
                        if (t.target_found && t.target_shoot) begin
                            if (streak < auto_need)
                                streak = streak + 4'd1;
                        end else begin
                            streak = '0;
                        end
                    end
                end else begin
                    streak = '0;
                end

                if (mode == MODE_MANUAL)
                    fire_cmd = t.fire_request && armed;
                else if (mode == MODE_AUTO)
                    fire_cmd = t.fire_request && armed && (streak >= auto_need);

                // feeder: manual reverse wins, then the jam machine
                if (t.reverse_request) begin
                    speed  = {1'b0, rev_spd};
                    jam    = JAM_NORMAL;
                    streak = '0;
                end else if (fire_cmd) begin
                    if (jam == JAM_REVERSING) begin
                        speed = {1'b0, rev_spd};
                        if (t.now_ms > reverse_until)
                            jam = JAM_NORMAL;
                    end else begin
                        speed = 16'h0 - {1'b0, feed_spd};
                        if (mag > {2'b0, jam_thr} && mag < {1'b0, valid_lim}) begin
                            jam_age = t.now_ms - jam_since;
                            if (jam == JAM_NORMAL) begin
                                jam       = JAM_BLOCKING;
                                jam_since = t.now_ms;
                            end else if (jam_age > {16'h0, confirm_ms}) begin
                                jam           = JAM_REVERSING;
                                reverse_until = t.now_ms + {16'h0, rev_dur_ms};
                            end
                        end else begin
                            jam = JAM_NORMAL;
                        end
                    end
                end else begin
                    jam = JAM_NORMAL;
                end
            end

            r.link_up         = online;
            r.gimbal_mode_out = mode;
            r.shooter_armed   = armed;
            r.friction_on     = online & armed;
            r.feeder_speed    = speed;
            r.angle_resync    = resync;
            r.jam_state_out   = jam;
            cmd_expected.push_back(r);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("MISMATCH: command %0d: %s", cmds_checked, msg);
        endfunction

        function void field_check(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                flag($sformatf("%s expected 0x%0h, got 0x%0h", field, want, got));
        endfunction

        // compare one command item from the block with the oldest expectation
        function void check_cmd(result_t got);
            result_t want;

            if (cmd_expected.size() == 0) begin
                flag($sformatf("item 0x%0h arrived with nothing expected", got));
                return;
            end
            want = cmd_expected.pop_front();
            field_check("link_up",         want.link_up,         got.link_up);
            field_check("gimbal_mode_out", want.gimbal_mode_out, got.gimbal_mode_out);
            field_check("shooter_armed",   want.shooter_armed,   got.shooter_armed);
            field_check("friction_on",     want.friction_on,     got.friction_on);
            field_check("feeder_speed",    want.feeder_speed,    got.feeder_speed);
            field_check("angle_resync",    want.angle_resync,    got.angle_resync);
            field_check("jam_state_out",   want.jam_state_out,   got.jam_state_out);
            cmds_checked++;
        endfunction

    endclass

endpackage

// ===== dv/testbench.sv =====
// ============================================================================
// testbench: shooter mode and feeder jam escape controller
// Directed ticks for edges, modes and jam escape, then shaped random control
// sessions across several register settings, with random stalls both sides.
// ============================================================================

module testbench;

    import smjec_pkg::*;
    import smjec_scoreboard_pkg::*;

    localparam int QUIET_LIMIT     = 1000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 100;

    // key masks for directed ticks
    localparam logic [6:0] K_NONE  = 7'b0000000;
    localparam logic [6:0] K_ARM   = 7'b0000001;
    localparam logic [6:0] K_RELAX = 7'b0000010;
    localparam logic [6:0] K_MODE  = 7'b0000100;
    localparam logic [6:0] K_FIRE  = 7'b0001000;
    localparam logic [6:0] K_REV   = 7'b0010000;
    localparam logic [6:0] K_FOUND = 7'b0100000;
    localparam logic [6:0] K_SHOOT = 7'b1000000;
    localparam logic [6:0] K_ALL   = 7'b1111111;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    cmd_scoreboard         sb;
    bit                    tx_gaps;
    bit                    rx_gaps;
    int unsigned           rx_hold   = 0;
    int unsigned           quiet     = 0;

    // stimulus shaping state
    logic [CFG_DATA_W-1:0] cfg_vals [8];
    logic [31:0]           clock_ms;
    bit                    arm_lvl, relax_lvl, mode_lvl, fire_lvl, rev_lvl;
    int unsigned           jam_left;
    int unsigned           offline_left;

    shooter_mode_jam_escape_ctrl_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // command sink with random stall bursts
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_cmd(result_t'(m_tdata));
        if (rx_hold != 0)
            rx_hold--;
        else if (rx_gaps && $urandom_range(0, 11) == 0)
            rx_hold = $urandom_range(1, 18);
        m_tready <= (rx_hold == 0);
    end

    // watchdog: too long with no item moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // offer one tick, with an optional idle burst first; returns once accepted
    task automatic send_tick(input tick_t t);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tdata  <= t;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_tick(t);
    endtask

    // stop sending and wait for every outstanding command item
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic program_regs();
        for (int i = REG_REMOTE_TIMEOUT; i <= REG_REVERSE_SPEED; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= cfg_vals[i];
            @(posedge aclk);
            sb.set_reg(CFG_IDX_W'(i), cfg_vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // register set and start time for one phase
    task automatic pick_config(input int p);
        case (p)
            1: begin
                cfg_vals[REG_REMOTE_TIMEOUT] = 16'hFFFF;
                cfg_vals[REG_JAM_THRESHOLD]  = 16'h7FFF;
                cfg_vals[REG_VALID_LIMIT]    = 16'd32768;
                cfg_vals[REG_JAM_CONFIRM]    = 16'hFFFF;
                cfg_vals[REG_REVERSE_DUR]    = 16'hFFFF;
                cfg_vals[REG_AUTO_CONFIRM]   = 16'd15;
                cfg_vals[REG_FEED_SPEED]     = 16'h7FFF;
                cfg_vals[REG_REVERSE_SPEED]  = 16'h7FFF;
            end
            2: begin
                for (int i = REG_REMOTE_TIMEOUT; i <= REG_REVERSE_SPEED; i++)
                    cfg_vals[i] = '0;
            end
            default: begin
                // moderate values so jams confirm and reverses end within a phase;
                // upper bits of narrow registers carry junk
                cfg_vals[REG_REMOTE_TIMEOUT] = 16'($urandom_range(0, 400));
                cfg_vals[REG_JAM_THRESHOLD]  = {1'($urandom()), 15'($urandom_range(0, 20000))};
                cfg_vals[REG_VALID_LIMIT]    =
                    16'($urandom_range(cfg_vals[REG_JAM_THRESHOLD][14:0], 32768));
                cfg_vals[REG_JAM_CONFIRM]    = 16'($urandom_range(0, 60));
                cfg_vals[REG_REVERSE_DUR]    = 16'($urandom_range(0, 80));
                cfg_vals[REG_AUTO_CONFIRM]   = {12'($urandom()), 4'($urandom_range(0, 4))};
                cfg_vals[REG_FEED_SPEED]     = 16'($urandom());
                cfg_vals[REG_REVERSE_SPEED]  = 16'($urandom());
            end
        endcase
        // some phases run across the 32-bit time wrap
        if (p == 3 || p == 5)
            clock_ms = 32'hFFFF_FF00 - $urandom_range(0, 2000);
        else if (p == 4)
            clock_ms = $urandom();
        else
            clock_ms = $urandom_range(0, 5000);
    endtask

    function automatic tick_t mk_tick(logic [31:0] now_v, logic [31:0] seen_v,
                                      logic [6:0] keys, logic [15:0] cur);
        tick_t t;
        t                = '0;
        t.now_ms         = now_v;
        t.remote_seen_ms = seen_v;
        {t.target_shoot, t.target_found, t.reverse_request, t.fire_request,
         t.mode_request, t.relax_request, t.arm_key} = keys;
        t.feeder_current = cur;
        return t;
    endfunction

    function automatic bit next_level(bit lvl, int unsigned press_pct, int unsigned rel_pct);
        if (lvl)
            return $urandom_range(0, 99) >= rel_pct;
        return $urandom_range(0, 99) < press_pct;
    endfunction

    // one tick of a plausible control session: time moves forward, keys are
    // held and released, jams come in bursts; a few ticks are pure noise
    function automatic tick_t next_tick();
        tick_t       t;
        int unsigned r;
        int          thr_i, lim_i, lo_i, hi_i, mag_i;

        t = '0;
        if ($urandom_range(0, 24) == 0) begin
            t.now_ms         = $urandom();
            t.remote_seen_ms = $urandom_range(0, 1) ? t.now_ms - $urandom_range(0, 300)
                                                   : $urandom();
            {t.target_shoot, t.target_found, t.reverse_request, t.fire_request,
             t.mode_request, t.relax_request, t.arm_key} = 7'($urandom());
            t.feeder_current = 16'($urandom());
            return t;
        end

        // time step
        r = $urandom_range(0, 99);
        if (r < 1)
            clock_ms = $urandom();
        else if (r < 6)
            clock_ms += $urandom_range(41, 400);
        else if (r < 30)
            clock_ms += $urandom_range(7, 40);
        else
            clock_ms += $urandom_range(0, 6);
        t.now_ms = clock_ms;

        // remote freshness, with short offline episodes
        if (offline_left == 0 && $urandom_range(0, 79) == 0)
            offline_left = $urandom_range(1, 5);
        if (offline_left != 0) begin
            offline_left--;
            t.remote_seen_ms = clock_ms - {16'h0, sb.timeout_ms} - 32'd1
                             - 32'($urandom_range(0, 1000));
        end else begin
            t.remote_seen_ms = clock_ms - $urandom_range(0, sb.timeout_ms);
        end

        // keys steer toward an armed, enabled gimbal
        arm_lvl   = next_level(arm_lvl, sb.armed ? 1 : 15, 50);
        relax_lvl = next_level(relax_lvl, (sb.mode == MODE_RELAX) ? 15 : 2, 50);
        mode_lvl  = next_level(mode_lvl, 4, 50);
        fire_lvl  = next_level(fire_lvl, 30, 8);
        rev_lvl   = next_level(rev_lvl, 2, 40);
        t.arm_key         = arm_lvl;
        t.relax_request   = relax_lvl;
        t.mode_request    = mode_lvl;
        t.fire_request    = fire_lvl;
        t.reverse_request = rev_lvl;
        t.target_found    = $urandom_range(0, 9) != 0;
        t.target_shoot    = $urandom_range(0, 4) != 0;

        // feeder current
        if (jam_left == 0 && $urandom_range(0, 11) == 0)
            jam_left = $urandom_range(5, 60);
        if (jam_left != 0)
            jam_left--;
        thr_i = int'(sb.jam_thr);
        lim_i = int'(sb.valid_lim);
        lo_i  = thr_i + 1;
        hi_i  = (lim_i > 32768) ? 32768 : lim_i - 1;
        r     = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 3))
                0:       mag_i = thr_i;
                1:       mag_i = thr_i + 1;
                2:       mag_i = lim_i - 1;
                default: mag_i = lim_i;
            endcase
        end else if (jam_left != 0 && lo_i <= hi_i) begin
            mag_i = $urandom_range(lo_i, hi_i);
        end else if (r < 70) begin
            mag_i = $urandom_range(0, thr_i);
        end else begin
            mag_i = -1;
        end

        if (mag_i < 0 || mag_i > 32768)
            t.feeder_current = 16'($urandom());
        else if (mag_i == 32768)
            t.feeder_current = 16'h8000;
        else if ($urandom_range(0, 1))
            t.feeder_current = 16'(-mag_i);
        else
            t.feeder_current = 16'(mag_i);
        return t;
    endfunction

    initial begin
        sb           = new();
        tx_gaps      = 1'b1;
        rx_gaps      = 1'b1;
        clock_ms     = '0;
        arm_lvl      = 1'b0;
        relax_lvl    = 1'b0;
        mode_lvl     = 1'b0;
        fire_lvl     = 1'b0;
        rev_lvl      = 1'b0;
        jam_left     = 0;
        offline_left = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed ticks on reset settings
        send_tick(mk_tick(1000, 0, K_ALL, 16'h8000));              // offline, keys ignored
        send_tick(mk_tick(1000, 1000, K_ARM, 16'h0000));           // arm
        send_tick(mk_tick(1002, 1000, K_RELAX, 16'h0000));         // manual, resync
        send_tick(mk_tick(1004, 1004, K_FIRE, 16'd9000));          // start blocking
        send_tick(mk_tick(1100, 1100, K_FIRE, 16'hDCD8));          // -9000, still blocking
        send_tick(mk_tick(1160, 1100, K_FIRE, 16'd9000));          // confirmed, reversing
        send_tick(mk_tick(1200, 1200, K_FIRE, 16'd9000));
        send_tick(mk_tick(1360, 1360, K_FIRE, 16'd9000));          // end time not yet passed
        send_tick(mk_tick(1361, 1361, K_FIRE, 16'd9000));          // back to normal
        send_tick(mk_tick(1362, 1362, K_FIRE, 16'h7FFF));          // above valid limit
        send_tick(mk_tick(1363, 1363, K_FIRE, 16'd8500));          // exactly at threshold
        send_tick(mk_tick(1364, 1364, K_MODE | K_FOUND | K_SHOOT | K_FIRE, 16'h0000));
        send_tick(mk_tick(1365, 1365, K_MODE | K_FOUND | K_SHOOT | K_FIRE, 16'h0000));
        send_tick(mk_tick(1366, 1366, K_FOUND | K_SHOOT | K_FIRE, 16'h0000));
        send_tick(mk_tick(1367, 1367, K_FOUND | K_FIRE, 16'h0000)); // streak broken
        send_tick(mk_tick(1368, 1368, K_REV | K_FIRE, 16'd9000));  // manual reverse
        send_tick(mk_tick(1369, 1369, K_RELAX | K_MODE | K_REV, 16'h0000));
        send_tick(mk_tick(1370, 1370, K_RELAX | K_FIRE, 16'h0000)); // relaxed never fires
        send_tick(mk_tick(1371, 1371, K_NONE, 16'h0000));
        send_tick(mk_tick(1372, 1372, K_RELAX | K_FIRE, 16'd9000));
        send_tick(mk_tick(5000, 1372, K_FIRE | K_ARM, 16'd9000));  // offline holds jam
        send_tick(mk_tick(5001, 5001, K_NONE, 16'h7FFF));
        send_tick(mk_tick(32'hFFFF_FFF0, 32'h0000_0010, K_ALL, 16'h0000));
        send_tick(mk_tick(32'h0000_0005, 32'hFFFF_FFF0, K_NONE, 16'h8000));
        clock_ms = 32'd8;

        // random sessions, one register set per phase; last phase runs flat out
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                drain();
                pick_config(p);
                program_regs();
                tx_gaps = (p != PHASES - 1);
                rx_gaps = (p != PHASES - 1);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_tick(next_tick());
        end

        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== shooter_mode_jam_escape_ctrl_core.f =====
rtl/core/smjec_pkg.sv
rtl/core/shooter_mode_jam_escape_ctrl_core.sv
dv/smjec_scoreboard_pkg.sv
dv/testbench.sv
